// ===== rtl/core/gfp_pkg.sv =====
`timescale 1ns / 1ps
package gfp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h40;
  localparam logic [7:0] CR_BYTE   = 8'h0d;
  localparam logic [7:0] LF_BYTE   = 8'h0a;

  localparam logic [2:0] REG_WEEK_SHIFT = 3'd0;
  localparam logic [2:0] REG_CLOCK_BIAS = 3'd1;
  localparam logic [2:0] REG_OSCILLATOR = 3'd2;
  localparam logic [2:0] REG_ACCURACY   = 3'd3;
  localparam logic [2:0] REG_PATCH_EN   = 3'd4;

  typedef struct packed {
    logic [7:0]  month;
    logic [7:0]  day;
    logic [15:0] year;
  } date_t;

  function automatic logic [7:0] frame_len(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] n;
    n = 8'd0;
    if (a == "A" && b == "w") n = 8'd8;
    if (a == "B" && b == "j") n = 8'd8;
    if (a == "C" && b == "f") n = 8'd7;
    if (a == "C" && b == "o") n = 8'd29;
    if (a == "G" && b == "d") n = 8'd8;
    if (a == "G" && b == "e") n = 8'd8;
    if (a == "G" && b == "f") n = 8'd9;
    if (a == "G" && b == "j") n = 8'd21;
    if (a == "H" && b == "a") n = 8'd154;
    if (a == "H" && b == "n") n = 8'd78;
    return n;
  endfunction

  function automatic logic [7:0] co_byte(input logic [4:0] i);
    logic [7:0] v;
    case (i)
      5'd0:  v = 8'd36;
      5'd1:  v = 8'd1;
      5'd2:  v = 8'd253;
      5'd3:  v = 8'd0;
      5'd4:  v = 8'd67;
      5'd5:  v = 8'd0;
      5'd6:  v = 8'd251;
      5'd7:  v = 8'd4;
      5'd11: v = 8'd1;
      5'd15: v = 8'd1;
      5'd16: v = 8'd18;
      5'd17: v = 8'd36;
      5'd18: v = 8'd4;
      5'd19: v = 8'd137;
      5'd20: v = 8'd7;
      5'd21: v = 8'd18;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // r is the year modulo 400
  function automatic logic is_leap(input logic [8:0] r);
    return (r[1:0] == 2'd0) && !(r == 9'd100 || r == 9'd200 || r == 9'd300);
  endfunction

  // m is zero-based
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd1:                      d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/gfp_date.sv =====
`timescale 1ns / 1ps
module gfp_date
  import gfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  month_in,
  input  logic [7:0]  day_in,
  input  logic [15:0] year_in,
  input  logic [15:0] shift,
  output logic        done,
  output date_t       result
);

  typedef enum logic [2:0] {S_IDLE, S_MON, S_MOD, S_BACK, S_WALK} state_t;

  state_t             state;
  logic signed [17:0] y;
  logic signed [17:0] d;
  logic [7:0]         mon;
  logic [17:0]        acc;
  logic [3:0]         k;
  logic [8:0]         r;

  logic [17:0] sub;
  logic [4:0]  dim;
  logic [8:0]  ylen;
  logic        leap;

  always_comb begin
    sub  = 18'(400) << k;
    leap = is_leap(r);
    dim  = month_days(mon[3:0], leap);
    ylen = leap ? 9'd366 : 9'd365;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (month_in == 8'd0) begin
              y   <= $signed({2'b00, year_in}) - 18'sd1;
              mon <= 8'd11;
            end else begin
              y   <= $signed({2'b00, year_in});
              mon <= month_in - 8'd1;
            end
            d     <= $signed({10'd0, day_in}) + $signed({2'b00, shift}) - 18'sd1;
            state <= S_MON;
          end
        end
        S_MON: begin
          if (mon >= 8'd12) begin
            mon <= mon - 8'd12;
            y   <= y + 18'sd1;
          end else begin
            acc   <= 18'(y + 18'sd400);
            k     <= 4'd8;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          // restoring reduction by 400
          if (acc >= sub) acc <= acc - sub;
          if (k == 4'd0) begin
            r     <= (acc >= sub) ? 9'(acc - sub) : acc[8:0];
            state <= d[17] ? S_BACK : S_WALK;
          end else begin
            k <= k - 4'd1;
          end
        end
        S_BACK: begin
          // day offset of minus one: last day of the previous month
          if (mon == 8'd0) begin
            mon <= 8'd11;
            y   <= y - 18'sd1;
            r   <= (r == 9'd0) ? 9'd399 : r - 9'd1;
            d   <= 18'sd30;
          end else begin
            mon <= mon - 8'd1;
            d   <= $signed({13'd0, month_days(mon[3:0] - 4'd1, leap)}) - 18'sd1;
          end
          state <= S_WALK;
        end
        S_WALK: begin
          if (mon == 8'd0 && d >= $signed({9'd0, ylen})) begin
            d <= d - $signed({9'd0, ylen});
            y <= y + 18'sd1;
            r <= (r == 9'd399) ? 9'd0 : r + 9'd1;
          end else if (d >= $signed({13'd0, dim})) begin
            d <= d - $signed({13'd0, dim});
            if (mon == 8'd11) begin
              mon <= 8'd0;
              y   <= y + 18'sd1;
              r   <= (r == 9'd399) ? 9'd0 : r + 9'd1;
            end else begin
              mon <= mon + 8'd1;
            end
          end else begin
            result.month <= mon + 8'd1;
            result.day   <= d[7:0] + 8'd1;
            result.year  <= y[15:0];
            done         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/gps_frame_filter_and_patcher.sv =====
`timescale 1ns / 1ps
// Binary GPS frame filter and patcher.
// Input channel: one received byte per request (in_valid, in_stall, rx_byte).
// Bytes are parsed on the fly and stored in a frame RAM; a byte is taken
// per cycle while parsing. Frames with an unknown id, bad checksum or bad
// terminator are dropped without output.
// On the LF of a good frame in_stall rises; a frame of an enabled patch kind
// is post-processed: Ha reads five bytes and runs the date walk (one year or
// month per cycle), patch writes go one byte at a time, and the checksum pass
// reads one byte per cycle over the frame. Every good frame is then sent up to
// four bytes per output request; each group is read byte by byte through the
// single RAM read port. in_stall falls when the last group is loaded.
// Output channel (out_valid, out_stall) has a holding register: a stalled
// group stays until taken, and the next group is read meanwhile.
// Configuration writes (cfg_valid, cfg_ready, always ready) are taken at any
// time and must only be issued while idle.
// Reset returns the parser to sync search; the frame RAM is not cleared.
module gps_frame_filter_and_patcher
  import gfp_pkg::*;
#(
  parameter int FRAME_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_a,
  output logic [7:0]  out_byte_b,
  output logic [7:0]  out_byte_c,
  output logic [7:0]  out_byte_d,
  output logic [2:0]  byte_count,
  output logic        last_group,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(FRAME_DEPTH);

  typedef enum logic [2:0] {
    PH_SYNC0, PH_SYNC1, PH_ID0, PH_ID1, PH_DATA, PH_SUM, PH_CR, PH_LF
  } phase_t;

  typedef enum logic [2:0] {
    ST_PARSE, ST_HA_RD, ST_DATE, ST_PWR, ST_CSUM, ST_CWR, ST_EMIT_RD, ST_EMIT_LD
  } state_t;

  typedef enum logic [1:0] {K_HA, K_HN, K_CO} kind_t;

  logic [15:0] week_shift_days;
  logic [15:0] clock_bias_bytes;
  logic [31:0] oscillator_bytes;
  logic [15:0] accuracy_fill;
  logic [2:0]  patch_enable;

  phase_t      phase;
  state_t      state;
  kind_t       kind;
  logic [AW:0] wp;
  logic [7:0]  id_a;
  logic [7:0]  id_b;
  logic [7:0]  run_xor;
  logic [7:0]  exp_len;
  logic [AW:0] flen;
  logic [2:0]  hk;
  logic [7:0]  hb [0:4];
  logic [4:0]  pk;
  logic [AW:0] ci;
  logic [7:0]  csum;
  logic [AW:0] eb;
  logic [2:0]  ej;
  logic        cap_v;
  logic [1:0]  cap_j;
  logic [7:0]  grp [0:3];
  logic        date_start;
  logic        date_done;
  date_t       date_res;

  logic [7:0]  mem [0:FRAME_DEPTH-1];
  logic [7:0]  rd_data;
  logic        we;
  logic [AW-1:0] waddr;
  logic [7:0]  wdata;
  logic [AW-1:0] raddr;

  logic        accept;
  logic [AW:0] wp_inc;
  logic [AW:0] rem;
  logic [2:0]  grp_n;
  logic [AW-1:0] p_addr;
  logic [7:0]  p_data;
  logic [4:0]  p_last;
  logic        out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_PARSE);
  assign accept    = in_valid && !in_stall;
  assign wp_inc    = wp + (AW+1)'(1);
  assign rem       = flen - eb;
  assign grp_n     = (rem < (AW+1)'(4)) ? rem[2:0] : 3'd4;
  assign out_free  = !out_valid || !out_stall;

  gfp_date u_date (
    .clk      (clk),
    .rst      (rst),
    .start    (date_start),
    .month_in (hb[0]),
    .day_in   (hb[1]),
    .year_in  ({hb[2], hb[3]}),
    .shift    (week_shift_days),
    .done     (date_done),
    .result   (date_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      week_shift_days  <= 16'd7168;
      clock_bias_bytes <= 16'd7424;
      oscillator_bytes <= 32'd16842752;
      accuracy_fill    <= 16'd65535;
      patch_enable     <= 3'd7;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WEEK_SHIFT: week_shift_days  <= cfg_data[15:0];
        REG_CLOCK_BIAS: clock_bias_bytes <= cfg_data[15:0];
        REG_OSCILLATOR: oscillator_bytes <= cfg_data;
        REG_ACCURACY:   accuracy_fill    <= cfg_data[15:0];
        REG_PATCH_EN:   patch_enable     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // patch write list per frame kind
  always_comb begin
    p_addr = '0;
    p_data = 8'd0;
    p_last = 5'd0;
    case (kind)
      K_HA: begin
        p_last = 5'd10;
        case (pk)
          5'd0: begin p_addr = AW'(4);   p_data = date_res.month; end
          5'd1: begin p_addr = AW'(5);   p_data = date_res.day; end
          5'd2: begin p_addr = AW'(6);   p_data = date_res.year[15:8]; end
          5'd3: begin p_addr = AW'(7);   p_data = date_res.year[7:0]; end
          5'd4: begin p_addr = AW'(129); p_data = hb[4] & 8'h7f; end
          5'd5: begin p_addr = AW'(133); p_data = clock_bias_bytes[15:8]; end
          5'd6: begin p_addr = AW'(134); p_data = clock_bias_bytes[7:0]; end
          5'd7: begin p_addr = AW'(135); p_data = oscillator_bytes[31:24]; end
          5'd8: begin p_addr = AW'(136); p_data = oscillator_bytes[23:16]; end
          5'd9: begin p_addr = AW'(137); p_data = oscillator_bytes[15:8]; end
          default: begin p_addr = AW'(138); p_data = oscillator_bytes[7:0]; end
        endcase
      end
      K_HN: begin
        p_last = 5'd1;
        p_addr = (pk == 5'd0) ? AW'(12) : AW'(13);
        p_data = (pk == 5'd0) ? accuracy_fill[15:8] : accuracy_fill[7:0];
      end
      default: begin
        p_last = 5'd21;
        p_addr = AW'(pk) + AW'(4);
        p_data = co_byte(pk);
      end
    endcase
  end

  // RAM port selection
  always_comb begin
    we    = 1'b0;
    waddr = wp[AW-1:0];
    wdata = rx_byte;
    raddr = '0;
    case (state)
      ST_PARSE: begin
        if (accept) begin
          if (phase == PH_SYNC0) begin
            we    = (rx_byte == SYNC_BYTE);
            waddr = '0;
          end else begin
            we = 1'b1;
          end
        end
      end
      ST_HA_RD: begin
        case (hk)
          3'd0:    raddr = AW'(4);
          3'd1:    raddr = AW'(5);
          3'd2:    raddr = AW'(6);
          3'd3:    raddr = AW'(7);
          default: raddr = AW'(129);
        endcase
      end
      ST_PWR: begin
        we    = 1'b1;
        waddr = p_addr;
        wdata = p_data;
      end
      ST_CSUM:    raddr = ci[AW-1:0];
      ST_CWR: begin
        we    = 1'b1;
        waddr = AW'(flen - (AW+1)'(3));
        wdata = csum;
      end
      ST_EMIT_RD: raddr = AW'(eb + (AW+1)'(ej));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SYNC0;
      state      <= ST_PARSE;
      wp         <= '0;
      id_a       <= 8'd0;
      id_b       <= 8'd0;
      run_xor    <= 8'd0;
      exp_len    <= 8'd0;
      cap_v      <= 1'b0;
      date_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      date_start <= 1'b0;
      cap_v      <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;

      if (cap_v) begin
        if (state == ST_CSUM) csum <= csum ^ rd_data;
        else grp[cap_j] <= rd_data;
      end

      unique case (state)
        ST_PARSE: begin
          if (accept) begin
            wp <= wp_inc;
            unique case (phase)
              PH_SYNC0: begin
                if (rx_byte == SYNC_BYTE) begin
                  wp    <= (AW+1)'(1);
                  phase <= PH_SYNC1;
                end else begin
                  wp <= '0;
                end
              end
              PH_SYNC1: begin
                run_xor <= 8'd0;
                phase   <= (rx_byte == SYNC_BYTE) ? PH_ID0 : PH_SYNC0;
              end
              PH_ID0: begin
                id_a    <= rx_byte;
                run_xor <= run_xor ^ rx_byte;
                phase   <= PH_ID1;
              end
              PH_ID1: begin
                id_b    <= rx_byte;
                run_xor <= run_xor ^ rx_byte;
                exp_len <= frame_len(id_a, rx_byte);
                if (frame_len(id_a, rx_byte) == 8'd0) phase <= PH_SYNC0;
                else if (frame_len(id_a, rx_byte) == 8'd7) phase <= PH_SUM;
                else phase <= PH_DATA;
              end
              PH_DATA: begin
                run_xor <= run_xor ^ rx_byte;
                if ({1'b0, wp_inc} + (AW+2)'(3) >= (AW+2)'(exp_len)) phase <= PH_SUM;
              end
              PH_SUM:  phase <= (rx_byte == run_xor) ? PH_CR : PH_SYNC0;
              PH_CR:   phase <= (rx_byte == CR_BYTE) ? PH_LF : PH_SYNC0;
              default: begin
                phase <= PH_SYNC0;
                if (rx_byte == LF_BYTE) begin
                  flen <= wp_inc;
                  eb   <= '0;
                  ej   <= 3'd0;
                  pk   <= 5'd0;
                  hk   <= 3'd0;
                  ci   <= (AW+1)'(2);
                  csum <= 8'd0;
                  if (id_a == "H" && id_b == "a" && patch_enable[0]) begin
                    kind  <= K_HA;
                    state <= ST_HA_RD;
                  end else if (id_a == "H" && id_b == "n" && patch_enable[1]) begin
                    kind  <= K_HN;
                    state <= ST_PWR;
                  end else if (id_a == "C" && id_b == "o" && patch_enable[2]) begin
                    kind  <= K_CO;
                    state <= ST_PWR;
                  end else begin
                    state <= ST_EMIT_RD;
                  end
                end
              end
            endcase
          end
        end
        ST_HA_RD: begin
          // read data arrives in the cycle after its address
          if (hk != 3'd0) hb[hk - 3'd1] <= rd_data;
          if (hk == 3'd5) begin
            date_start <= 1'b1;
            state      <= ST_DATE;
          end else begin
            hk <= hk + 3'd1;
          end
        end
        ST_DATE: begin
          if (date_done) state <= ST_PWR;
        end
        ST_PWR: begin
          pk <= pk + 5'd1;
          if (pk == p_last) state <= ST_CSUM;
        end
        ST_CSUM: begin
          if (ci + (AW+1)'(4) <= flen) begin
            cap_v <= 1'b1;
            ci    <= ci + (AW+1)'(1);
          end else if (!cap_v) begin
            state <= ST_CWR;
          end
        end
        ST_CWR: state <= ST_EMIT_RD;
        ST_EMIT_RD: begin
          cap_v <= 1'b1;
          cap_j <= ej[1:0];
          if (ej + 3'd1 == grp_n) state <= ST_EMIT_LD;
          else ej <= ej + 3'd1;
        end
        ST_EMIT_LD: begin
          if (!cap_v && out_free) begin
            out_valid  <= 1'b1;
            out_byte_a <= grp[0];
            out_byte_b <= (grp_n > 3'd1) ? grp[1] : 8'd0;
            out_byte_c <= (grp_n > 3'd2) ? grp[2] : 8'd0;
            out_byte_d <= (grp_n > 3'd3) ? grp[3] : 8'd0;
            byte_count <= grp_n;
            last_group <= (rem <= (AW+1)'(4));
            eb         <= eb + (AW+1)'(4);
            ej         <= 3'd0;
            state      <= (rem <= (AW+1)'(4)) ? ST_PARSE : ST_EMIT_RD;
          end
        end
        default: state <= ST_PARSE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_PARSE) |-> in_stall)
    else $error("input taken while frame is processed");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count != 3'd0 && byte_count <= 3'd4))
    else $error("group byte count out of range");

  a_short_group_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_count != 3'd4) |-> last_group)
    else $error("partial group not marked last");
`endif

endmodule

// ===== test/gps_frame_filter_and_patcher_test.sv =====
`timescale 1ns / 1ps
module gps_frame_filter_and_patcher_test
  import gfp_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 900;
  localparam int LONG_HOLD      = 3000;

  typedef enum {F_NONE, F_SUM, F_CR, F_LF, F_RESYNC, F_NOISE} fault_t;
  typedef enum {S_SYNC0, S_SYNC1, S_ID0, S_ID1, S_DATA, S_SUM, S_CR, S_LF} scan_t;

  typedef struct {
    logic [7:0] a, b, c, d;
    logic [2:0] n;
    logic       last;
  } group_t;

  typedef struct {
    logic [7:0] id_a, id_b;
    fault_t     fault;
    int         date_mode;   // 0 random, 1 all zero, 2 all ones
    bit         dropped;     // frame must yield no output
  } row_t;

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, out_stall = 0, cfg_valid = 0;
  logic [7:0]  rx_byte = 0;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic        in_stall, out_valid, cfg_ready, last_group;
  logic [7:0]  out_byte_a, out_byte_b, out_byte_c, out_byte_d;
  logic [2:0]  byte_count;

  gps_frame_filter_and_patcher u_top (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // shadow of the block
  logic [15:0] sh_week, sh_bias, sh_acc;
  logic [31:0] sh_osc;
  logic [2:0]  sh_pe;
  scan_t       sh_scan;
  logic [7:0]  sh_store [256];
  int          sh_wpos;
  logic [7:0]  sh_id0, sh_id1, sh_xor, sh_len;

  // fixed Co bytes 4..25
  logic [7:0]  co_fix [22] = '{8'd36, 8'd1, 8'd253, 8'd0, 8'd67, 8'd0, 8'd251, 8'd4,
                               8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1,
                               8'd18, 8'd36, 8'd4, 8'd137, 8'd7, 8'd18};

  logic [7:0]  rx_fifo[$];
  group_t      pending_groups[$];
  int          fails = 0, groups_made = 0, groups_seen = 0, frames_sent = 0, cfg_writes = 0;
  bit          long_hold_req = 0;

  function automatic logic [7:0] id_length(logic [7:0] a, logic [7:0] b);
    case ({a, b})
      "Aw", "Bj", "Gd", "Ge": return 8'd8;
      "Cf": return 8'd7;
      "Co": return 8'd29;
      "Gf": return 8'd9;
      "Gj": return 8'd21;
      "Ha": return 8'd154;
      "Hn": return 8'd78;
      default: return 8'd0;
    endcase
  endfunction

  function automatic longint days_of(longint y, longint m, longint d);
    longint era, yoe, doy, doe;
    y -= (m <= 2) ? 1 : 0;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  task automatic civil_date(input longint z, output longint y, output longint m,
                            output longint d);
    longint era, doe, yoe, doy, mp;
    z += 719468;
    era = (z >= 0 ? z : z - 146096) / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    d = doy - (153 * mp + 2) / 5 + 1;
    m = mp < 10 ? mp + 3 : mp - 9;
    y = yoe + era * 400 + (m <= 2 ? 1 : 0);
  endtask

  task automatic reseal(int len);
    logic [7:0] x;
    x = 0;
    for (int i = 2; i + 4 <= len; i++) x ^= sh_store[i];
    sh_store[len-3] = x;
  endtask

  task automatic shift_ha_date();
    longint mon, yr, mday, ny, nm, nd;
    logic [15:0] yb;
    mon = longint'(sh_store[4]) - 1;
    yr = longint'(sh_store[6]) * 256 + sh_store[7];
    mday = longint'(sh_store[5]) + sh_week;
    if (mon < 0) begin
      yr -= 1;
      mon += 12;
    end
    yr += mon / 12;
    mon = mon % 12;
    civil_date(days_of(yr, mon + 1, 1) + mday - 1, ny, nm, nd);
    yb = ny[15:0];
    sh_store[4] = nm[7:0];
    sh_store[5] = nd[7:0];
    sh_store[6] = yb[15:8];
    sh_store[7] = yb[7:0];
    sh_store[129] &= 8'h7f;
    {sh_store[133], sh_store[134]} = sh_bias;
    {sh_store[135], sh_store[136], sh_store[137], sh_store[138]} = sh_osc;
  endtask

  task automatic take_byte(logic [7:0] c);
    int len, n;
    group_t g;
    if (sh_wpos < 256) sh_store[sh_wpos] = c;
    sh_wpos++;
    case (sh_scan)
      S_SYNC0: begin
        sh_wpos = 0;
        if (c == SYNC_BYTE) begin
          sh_store[0] = c;
          sh_wpos = 1;
          sh_scan = S_SYNC1;
        end
      end
      S_SYNC1: begin
        if (c == SYNC_BYTE) begin
          sh_xor = 0;
          sh_scan = S_ID0;
        end else sh_scan = S_SYNC0;
      end
      S_ID0: begin
        sh_id0 = c;
        sh_xor ^= c;
        sh_scan = S_ID1;
      end
      S_ID1: begin
        sh_id1 = c;
        sh_xor ^= c;
        sh_len = id_length(sh_id0, c);
        if (sh_len == 0) sh_scan = S_SYNC0;
        else if (sh_len == 7) sh_scan = S_SUM;
        else sh_scan = S_DATA;
      end
      S_DATA: begin
        sh_xor ^= c;
        if (sh_wpos + 3 >= sh_len) sh_scan = S_SUM;
      end
      S_SUM: sh_scan = (c == sh_xor) ? S_CR : S_SYNC0;
      S_CR: sh_scan = (c == CR_BYTE) ? S_LF : S_SYNC0;
      default: begin
        sh_scan = S_SYNC0;
        if (c == LF_BYTE) begin
          len = sh_wpos;
          if ({sh_id0, sh_id1} == "Ha") begin
            if (sh_pe[0]) begin
              shift_ha_date();
              reseal(len);
            end
          end else if ({sh_id0, sh_id1} == "Hn") begin
            if (sh_pe[1]) begin
              {sh_store[12], sh_store[13]} = sh_acc;
              reseal(len);
            end
          end else if ({sh_id0, sh_id1} == "Co") begin
            if (sh_pe[2]) begin
              for (int i = 0; i < 22; i++) sh_store[i + 4] = co_fix[i];
              reseal(len);
            end
          end
          for (int i = 0; i < len; i += 4) begin
            n = (len - i < 4) ? len - i : 4;
            g.a = sh_store[i];
            g.b = n > 1 ? sh_store[i+1] : 8'd0;
            g.c = n > 2 ? sh_store[i+2] : 8'd0;
            g.d = n > 3 ? sh_store[i+3] : 8'd0;
            g.n = n[2:0];
            g.last = (i + 4 >= len);
            pending_groups.push_back(g);
            groups_made++;
          end
        end
      end
    endcase
  endtask

  // sender: bursts with gaps; a stalled request holds its byte
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        take_byte(rx_byte);
        void'(rx_fifo.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 0;
        end else if (rx_fifo.size() > 0) begin
          in_valid <= 1;
          rx_byte <= rx_fifo[0];
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
            gap_left = $urandom_range(0, 6);
          end
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // receiver stall pattern, plus one long hold on request
  int stall_mode = 0, mode_left = 0, hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else if (long_hold_req) begin
      long_hold_req = 0;
      hold_left = LONG_HOLD;
      out_stall <= 1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    group_t g;
    if (!rst && out_valid && !out_stall) begin
      groups_seen++;
      if (pending_groups.size() == 0) begin
        $error("result with no expectation: a=%h count=%0d", out_byte_a, byte_count);
        fails++;
      end else begin
        g = pending_groups.pop_front();
        if (out_byte_a !== g.a) begin $error("out_byte_a exp %h got %h", g.a, out_byte_a); fails++; end
        if (out_byte_b !== g.b) begin $error("out_byte_b exp %h got %h", g.b, out_byte_b); fails++; end
        if (out_byte_c !== g.c) begin $error("out_byte_c exp %h got %h", g.c, out_byte_c); fails++; end
        if (out_byte_d !== g.d) begin $error("out_byte_d exp %h got %h", g.d, out_byte_d); fails++; end
        if (byte_count !== g.n) begin $error("byte_count exp %0d got %0d", g.n, byte_count); fails++; end
        if (last_group !== g.last) begin
          $error("last_group exp %b got %b", g.last, last_group);
          fails++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("gps_frame_filter_and_patcher regression: fail");
      $finish;
    end
  end

  // called right after posedge clk; leaves cfg_valid high
  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      REG_WEEK_SHIFT: sh_week = val[15:0];
      REG_CLOCK_BIAS: sh_bias = val[15:0];
      REG_OSCILLATOR: sh_osc = val;
      REG_ACCURACY:   sh_acc = val[15:0];
      REG_PATCH_EN:   sh_pe = val[2:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (rx_fifo.size() != 0 || in_valid || pending_groups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] wk, logic [15:0] cb, logic [31:0] osc,
                          logic [15:0] acc, logic [2:0] pe);
    wait_idle();
    cfg_write(REG_WEEK_SHIFT, {16'd0, wk});
    cfg_write(REG_CLOCK_BIAS, {16'd0, cb});
    cfg_write(REG_OSCILLATOR, osc);
    cfg_write(REG_ACCURACY, {16'd0, acc});
    cfg_write(REG_PATCH_EN, {29'd0, pe});
    cfg_valid <= 0;
  endtask

  task automatic queue_frame(logic [7:0] a, logic [7:0] b, fault_t f, int date_mode);
    int len;
    logic [7:0] x, v;
    frames_sent++;
    if (f == F_NOISE) begin
      repeat ($urandom_range(1, 6))
        rx_fifo.push_back($urandom_range(0, 1) ? SYNC_BYTE : 8'($urandom));
      return;
    end
    if (f == F_RESYNC) begin
      rx_fifo.push_back(SYNC_BYTE);
      rx_fifo.push_back(8'($urandom_range(0, 1) ? 8'h41 : 8'h00));
    end
    len = id_length(a, b);
    rx_fifo.push_back(SYNC_BYTE);
    rx_fifo.push_back(SYNC_BYTE);
    rx_fifo.push_back(a);
    rx_fifo.push_back(b);
    x = a ^ b;
    if (len == 0) return;
    for (int i = 4; i < len - 3; i++) begin
      v = 8'($urandom);
      if (i >= 4 && i <= 7 && date_mode == 1) v = 8'h00;
      if (i >= 4 && i <= 7 && date_mode == 2) v = 8'hff;
      if (date_mode == 0 && i == 4 && $urandom_range(0, 1)) v = 8'($urandom_range(1, 12));
      if (date_mode == 0 && i == 5 && $urandom_range(0, 1)) v = 8'($urandom_range(1, 31));
      if (date_mode == 0 && i == 6 && $urandom_range(0, 1)) v = 8'h07;
      x ^= v;
      rx_fifo.push_back(v);
    end
    rx_fifo.push_back(f == F_SUM ? x ^ (8'd1 << $urandom_range(0, 7)) : x);
    rx_fifo.push_back(f == F_CR ? CR_BYTE ^ 8'($urandom_range(1, 255)) : CR_BYTE);
    rx_fifo.push_back(f == F_LF ? LF_BYTE ^ 8'($urandom_range(1, 255)) : LF_BYTE);
  endtask

  task automatic random_frames(int count);
    logic [7:0] ids [10][2] = '{'{"A", "w"}, '{"B", "j"}, '{"C", "f"}, '{"C", "o"},
                                '{"G", "d"}, '{"G", "e"}, '{"G", "f"}, '{"G", "j"},
                                '{"H", "a"}, '{"H", "n"}};
    int r, k;
    fault_t f;
    repeat (count) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 7);
      if (r < 6) k = 8;
      else if (r < 18) k = 9;
      else if (r < 30) k = 3;
      f = F_NONE;
      if (r >= 75) f = fault_t'($urandom_range(F_SUM, F_NOISE));
      if (r >= 95)
        queue_frame(8'($urandom), 8'($urandom), F_NONE, 0);
      else
        queue_frame(ids[k][0], ids[k][1], f, $urandom_range(0, 5) == 0 ? 2 : 0);
    end
  endtask

  row_t rows [12] = '{
    '{"C", "f", F_NONE,   0, 0},
    '{"A", "w", F_NONE,   0, 0},
    '{"G", "j", F_NONE,   0, 0},
    '{"C", "o", F_NONE,   0, 0},
    '{"H", "n", F_NONE,   0, 0},
    '{"H", "a", F_NONE,   1, 0},
    '{"H", "a", F_NONE,   2, 0},
    '{"X", "x", F_NONE,   0, 1},
    '{"G", "d", F_SUM,    0, 1},
    '{"G", "e", F_CR,     0, 1},
    '{"G", "f", F_LF,     0, 1},
    '{"B", "j", F_RESYNC, 0, 0}
  };

  initial begin
    int before_row;
    sh_week = 16'd7168;
    sh_bias = 16'd7424;
    sh_osc = 32'd16842752;
    sh_acc = 16'hffff;
    sh_pe = 3'd7;
    sh_scan = S_SYNC0;
    sh_wpos = 0;
    sh_id0 = 0;
    sh_id1 = 0;
    sh_xor = 0;
    sh_len = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    set_regs(16'd0, 16'd0, 32'd0, 16'd0, 3'd7);
    foreach (rows[i]) begin
      before_row = groups_made;
      queue_frame(rows[i].id_a, rows[i].id_b, rows[i].fault, rows[i].date_mode);
      while (rx_fifo.size() != 0 || in_valid) @(posedge clk);
      if ((groups_made != before_row) == rows[i].dropped) begin
        $error("row %0d: dropped exp %b got %b", i, rows[i].dropped,
               groups_made == before_row);
        fails++;
      end
    end

    set_regs(16'hffff, 16'hffff, 32'hffffffff, 16'hffff, 3'd7);
    queue_frame("H", "a", F_NONE, 2);
    random_frames(8);

    set_regs(16'd7168, 16'd7424, 32'd16842752, 16'hffff, 3'd0);
    random_frames(8);

    set_regs(16'($urandom), 16'($urandom), $urandom, 16'($urandom), 3'($urandom));
    long_hold_req = 1;
    queue_frame("H", "a", F_NONE, 0);
    queue_frame("H", "n", F_NONE, 0);
    random_frames(10);

    set_regs(16'($urandom_range(0, 400)), 16'($urandom), $urandom, 16'($urandom),
             3'($urandom_range(1, 7)));
    random_frames(12);

    wait_idle();
    $display("covered %0d frames, %0d groups checked, %0d register writes",
             frames_sent, groups_seen, cfg_writes);
    $display("ids: all ten known ones, unknown, bad sum/CR/LF, resync and noise");
    if (fails == 0) $display("gps_frame_filter_and_patcher regression: pass");
    else $display("gps_frame_filter_and_patcher regression: fail");
    $finish;
  end

endmodule
